FILE: rtl/dfm_pkg.sv
// shared types and constants for the double multiply pipeline
// no dependencies
package dfm_pkg;

   localparam int unsigned HighWidth = 32;
   localparam int unsigned LowWidth  = 21;
   localparam int unsigned ExpWidth  = 11;
   localparam int unsigned FracWidth = 52;

   localparam logic [ExpWidth:0]   ExpBiasUp   = 12'd1022;
   localparam logic [ExpWidth:0]   ExpBias     = 12'd1023;
   localparam logic [ExpWidth:0]   ExpMax      = 12'd2047;
   localparam logic [63:0]         RoundHalf11 = 64'd1024;
   localparam logic [63:0]         RoundHalf10 = 64'd512;

   // decoded operand pair
   typedef struct packed {
      logic                 sign;
      logic                 zero;
      logic [ExpWidth:0]    exp_sum;
      logic [HighWidth-1:0] ha;
      logic [HighWidth-1:0] hb;
      logic [LowWidth-1:0]  la;
      logic [LowWidth-1:0]  lb;
   } unpack_type;

   // working sum ready for rounding
   typedef struct packed {
      logic              sign;
      logic              zero;
      logic [ExpWidth:0] exp_sum;
      logic [63:0]       sum;
   } sum_type;

endpackage

FILE: rtl/dfm_unpack.sv
// operand decode stage: sign, zero check, exponent sum, significand split
// depends on dfm_pkg
module dfm_unpack (
   input  logic                clock,
   input  logic                enable,
   input  logic [63:0]         operand_a,
   input  logic [63:0]         operand_b,
   output dfm_pkg::unpack_type unpack
);
   import dfm_pkg::*;

   unpack_type unpack_ff, unpack_in;
   logic [52:0] ma, mb;

   // split significands with hidden one inserted
   always_comb begin
      ma = {1'b1, operand_a[51:0]};
      mb = {1'b1, operand_b[51:0]};
      unpack_in.sign    = operand_a[63] ^ operand_b[63];
      unpack_in.zero    = (operand_a[62:0] == '0) || (operand_b[62:0] == '0);
      unpack_in.exp_sum = {1'b0, operand_a[62:52]} + {1'b0, operand_b[62:52]};
      unpack_in.ha      = ma[52:21];
      unpack_in.hb      = mb[52:21];
      unpack_in.la      = ma[20:0];
      unpack_in.lb      = mb[20:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         unpack_ff <= unpack_in;
      end
   end

   assign unpack = unpack_ff;

endmodule

FILE: rtl/dfm_mult.sv
// partial product stage and accumulate stage
// depends on dfm_pkg
module dfm_mult (
   input  logic                clock,
   input  logic                enable,
   input  dfm_pkg::unpack_type unpack,
   output dfm_pkg::sum_type    sum
);
   import dfm_pkg::*;

   logic [63:0] hh_ff, hh_in;
   logic [52:0] lh_ff, lh_in;
   logic [52:0] hl_ff, hl_in;
   logic        sign_ff, zero_ff;
   logic [ExpWidth:0] exp_ff;
   sum_type     sum_ff, sum_in;

   // three partial products, low times low dropped
   always_comb begin
      hh_in = unpack.ha * unpack.hb;
      lh_in = unpack.la * unpack.hb;
      hl_in = unpack.lb * unpack.ha;
   end

   // add cross terms scaled down
   always_comb begin
      sum_in.sign    = sign_ff;
      sum_in.zero    = zero_ff;
      sum_in.exp_sum = exp_ff;
      sum_in.sum     = hh_ff + {32'd0, lh_ff[52:21]} + {32'd0, hl_ff[52:21]};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         hh_ff   <= hh_in;
         lh_ff   <= lh_in;
         hl_ff   <= hl_in;
         sign_ff <= unpack.sign;
         zero_ff <= unpack.zero;
         exp_ff  <= unpack.exp_sum;
         sum_ff  <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

FILE: rtl/dfm_round.sv
// normalize, round half up, range check and pack
// depends on dfm_pkg
module dfm_round (
   input  logic             clock,
   input  logic             enable,
   input  dfm_pkg::sum_type sum,
   output logic [63:0]      product,
   output logic             overflowed
);
   import dfm_pkg::*;

   logic [63:0]       product_ff, product_in;
   logic              overflowed_ff, overflowed_in;
   logic [63:0]       rounded;
   logic [FracWidth-1:0] frac;
   logic [ExpWidth+1:0]  exp;

   always_comb begin
      // pick shift from top bit before or after rounding
      if (sum.sum[63]) begin
         rounded = sum.sum + RoundHalf11;
         frac    = rounded[62:11];
         exp     = {1'b0, sum.exp_sum} - {1'b0, ExpBiasUp};
      end else begin
         rounded = sum.sum + RoundHalf10;
         if (rounded[63]) begin
            frac = rounded[62:11];
            exp  = {1'b0, sum.exp_sum} - {1'b0, ExpBiasUp};
         end else begin
            frac = rounded[61:10];
            exp  = {1'b0, sum.exp_sum} - {1'b0, ExpBias};
         end
      end
      // range check on signed exponent
      overflowed_in = 1'b0;
      product_in    = {sum.sign, 63'd0};
      if (!sum.zero) begin
         if (!exp[ExpWidth+1] && (exp[ExpWidth:0] >= ExpMax)) begin
            overflowed_in = 1'b1;
            product_in    = {sum.sign, {ExpWidth{1'b1}}, {FracWidth{1'b0}}};
         end else if (!exp[ExpWidth+1] && (exp != '0)) begin
            product_in = {sum.sign, exp[ExpWidth-1:0], frac};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff    <= product_in;
         overflowed_ff <= overflowed_in;
      end
   end

   assign product    = product_ff;
   assign overflowed = overflowed_ff;

endmodule

FILE: rtl/double_float_multiply.sv
// Double precision multiplier, four register stages: decode, partial
// products (three multipliers of at most 32x32 bits), accumulate, and
// round/pack into the output register. One word enters every cycle unless
// req_stall is set. The whole pipe holds while a result waits under
// rsp_stall, so req_stall follows rsp_stall then.
// Rounding is half up on a truncated product, zero and underflow give a
// signed zero, overflow gives a signed infinity with rsp_overflowed set.
// depends on dfm_pkg, dfm_unpack, dfm_mult, dfm_round
module double_float_multiply (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_operand_a,
   input  logic [63:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_product,
   output logic        rsp_overflowed
);
   import dfm_pkg::*;

   logic [3:0] valid_ff, valid_in;
   logic       enable;
   unpack_type unpack;
   sum_type    sum;

   // pipe moves unless a result is held
   assign enable    = !(valid_ff[3] && rsp_stall);
   assign req_stall = !enable;
   assign valid_in  = {valid_ff[2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   dfm_unpack u_unpack (
      .clock     (clock),
      .enable    (enable),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .unpack    (unpack)
   );

   dfm_mult u_mult (
      .clock  (clock),
      .enable (enable),
      .unpack (unpack),
      .sum    (sum)
   );

   dfm_round u_round (
      .clock      (clock),
      .enable     (enable),
      .sum        (sum),
      .product    (rsp_product),
      .overflowed (rsp_overflowed)
   );

   assign rsp_valid = valid_ff[3];

endmodule
